/* design/ovtp_pkg.sv */
package ovtp_pkg;

  localparam int STEPS_W = 8;
  localparam int HOLD_W  = 8;
  localparam int SPEED_W = 14;
  localparam int VEL_W   = 15;
  localparam int TICK_W  = 7;
  localparam int PROD_W  = SPEED_W + STEPS_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SPEED_W;

  localparam logic [TICK_W-1:0] RAMP_TICKS = TICK_W'(2);
  localparam logic [TICK_W-1:0] HOLD_TICKS = TICK_W'(10);
  localparam int PAUSE_TICKS_DEF = 100;

  localparam logic [STEPS_W-1:0] RAMP_STEPS_RST   = STEPS_W'(100);
  localparam logic [HOLD_W-1:0]  HOLD_PERIODS_RST = HOLD_W'(100);
  localparam logic [SPEED_W-1:0] TOP_SPEED_RST    = SPEED_W'(5000);

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIODS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED    = CFG_IDX_W'(2);

  typedef struct packed {
    logic               load;
    logic               step;
    logic               push;
    logic [STEPS_W-1:0] idx;
    logic               neg;
    logic               fin;
  } ovtp_cmd_t;

  typedef struct packed {
    logic out_free;
  } ovtp_status_t;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

/* design/ovtp_dp.sv */
module ovtp_dp
  import ovtp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic [STEPS_W-1:0]        ramp_steps,
  input  logic [SPEED_W-1:0]        top_speed,
  input  ovtp_cmd_t                 cmd,
  output ovtp_status_t              status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VEL_W-1:0]   velocity,
  output logic                      finished
);

  logic [PROD_W-1:0]  quo;
  logic [STEPS_W-1:0] rem;
  logic [STEPS_W-1:0] dvs;
  logic               neg;
  logic               fin;

  logic [PROD_W-1:0]  prod;
  logic [STEPS_W:0]   rem_sh;
  logic               qbit;
  logic [STEPS_W-1:0] rem_next;
  logic [VEL_W-1:0]   vel_u;
  logic [VEL_W-1:0]   vel;

  assign prod     = PROD_W'(top_speed) * PROD_W'(cmd.idx);
  assign rem_sh   = {rem, quo[PROD_W-1]};
  assign qbit     = rem_sh >= {1'b0, dvs};
  assign rem_next = qbit ? STEPS_W'(rem_sh - {1'b0, dvs}) : rem_sh[STEPS_W-1:0];
  assign vel_u    = {1'b0, quo[SPEED_W-1:0]};
  assign vel      = neg ? (~vel_u + VEL_W'(1)) : vel_u;

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= prod;
      rem <= '0;
      dvs <= at_least_one(ramp_steps);
      neg <= cmd.neg;
      fin <= cmd.fin;
    end else if (cmd.step) begin
      quo <= {quo[PROD_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      velocity <= $signed(vel);
      finished <= fin;
    end
  end

endmodule

/* design/ovtp_ctrl.sv */
module ovtp_ctrl
  import ovtp_pkg::*;
#(
  parameter int PAUSE_TICKS = PAUSE_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               button_pressed,
  input  logic [STEPS_W-1:0] ramp_steps,
  input  logic [HOLD_W-1:0]  hold_periods,
  output ovtp_cmd_t          cmd,
  input  ovtp_status_t       status
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_UP_F, PH_HOLD_F, PH_DOWN_F, PH_PAUSE, PH_UP_R, PH_HOLD_R, PH_DOWN_R
  } phase_t;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;
  phase_t               phase, phase_next;
  logic [STEPS_W-1:0]   ramp_index, ramp_index_next;
  logic [HOLD_W-1:0]    hold_count, hold_count_next;
  logic [TICK_W-1:0]    tick_wait, tick_wait_next;

  logic               accept;
  logic               emit;
  logic [STEPS_W-1:0] e_idx;
  logic               e_neg;
  logic               e_fin;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    logic [STEPS_W-1:0] a;
    logic [HOLD_W-1:0]  eh;
    logic               bnd;
    logic               abrt;
    logic               down_go;
    logic               rev;
    logic [STEPS_W-1:0] down_src;
    logic [STEPS_W-1:0] i;
    phase_t             cur;

    a        = at_least_one(ramp_steps);
    eh       = at_least_one(hold_periods);
    bnd      = 1'b0;
    abrt     = 1'b0;
    down_go  = 1'b0;
    down_src = ramp_index;
    i        = '0;
    cur      = phase;

    phase_next      = phase;
    ramp_index_next = ramp_index;
    hold_count_next = hold_count;
    tick_wait_next  = tick_wait;
    emit  = 1'b0;
    e_idx = '0;
    e_neg = 1'b0;
    e_fin = 1'b0;

    if (phase == PH_IDLE) begin
      if (action) begin
        bnd             = 1'b1;
        cur             = PH_UP_F;
        phase_next      = PH_UP_F;
        ramp_index_next = '0;
        hold_count_next = '0;
        tick_wait_next  = '0;
        down_src        = '0;
      end
    end else if (!action) begin
      if (tick_wait > TICK_W'(1)) begin
        tick_wait_next = tick_wait - TICK_W'(1);
      end else begin
        tick_wait_next = '0;
        bnd            = 1'b1;
      end
    end

    rev = (cur == PH_UP_R) || (cur == PH_HOLD_R) || (cur == PH_DOWN_R);

    if (bnd) begin
      unique case (cur)
        PH_UP_F, PH_UP_R: begin
          if (button_pressed) begin
            abrt = 1'b1;
          end else begin
            i = (ramp_index_next < a) ? ramp_index_next : a;
            emit  = 1'b1;
            e_idx = i;
            e_neg = rev;
            tick_wait_next = RAMP_TICKS;
            if (i >= a) begin
              phase_next      = rev ? PH_HOLD_R : PH_HOLD_F;
              hold_count_next = '0;
            end else begin
              ramp_index_next = i + STEPS_W'(1);
            end
          end
        end
        PH_HOLD_F, PH_HOLD_R: begin
          if (button_pressed) begin
            abrt = 1'b1;
          end else begin
            if (hold_count == '0) begin
              emit  = 1'b1;
              e_idx = a;
              e_neg = rev;
            end
            if (hold_count < eh) begin
              hold_count_next = hold_count + HOLD_W'(1);
              tick_wait_next  = HOLD_TICKS;
            end else begin
              phase_next = rev ? PH_DOWN_R : PH_DOWN_F;
              down_go    = 1'b1;
              down_src   = a;
            end
          end
        end
        PH_DOWN_F, PH_DOWN_R: begin
          if (button_pressed) begin
            abrt = 1'b1;
          end else begin
            down_go = 1'b1;
          end
        end
        PH_PAUSE: begin
          tick_wait_next  = TICK_W'(PAUSE_TICKS);
          phase_next      = PH_UP_R;
          ramp_index_next = '0;
        end
        default: begin
        end
      endcase

      if (down_go) begin
        i = (down_src < a) ? down_src : a;
        if (i == '0) begin
          i = STEPS_W'(1);
        end
        emit  = 1'b1;
        e_idx = i;
        e_neg = rev;
        tick_wait_next = RAMP_TICKS;
        if (i <= STEPS_W'(1)) begin
          phase_next      = rev ? PH_UP_F : PH_PAUSE;
          ramp_index_next = '0;
        end else begin
          ramp_index_next = i - STEPS_W'(1);
        end
      end

      if (abrt) begin
        phase_next      = PH_IDLE;
        ramp_index_next = '0;
        hold_count_next = '0;
        tick_wait_next  = '0;
        emit  = 1'b1;
        e_idx = '0;
        e_neg = 1'b0;
        e_fin = 1'b1;
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.idx  = e_idx;
    cmd.neg  = e_neg;
    cmd.fin  = e_fin;
    cmd.load = accept && emit;
    cmd.step = (state == S_DIV);
    cmd.push = (state == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      phase      <= PH_IDLE;
      ramp_index <= '0;
      hold_count <= '0;
      tick_wait  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            phase      <= phase_next;
            ramp_index <= ramp_index_next;
            hold_count <= hold_count_next;
            tick_wait  <= tick_wait_next;
            if (emit) begin
              state <= S_DIV;
              cnt   <= '0;
            end
          end
        end
        S_DIV: begin
          cnt <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/oscillating_trapezoid_velocity_profile_unit.sv */
// A beat with a result is loaded into the bit-serial divider for top_speed*i/ramp_steps,
// divided one quotient bit per step, and pushed once the output register is free; the
// input stalls until that push. Ticks with no result: one item per cycle.
// Reset: synchronous, clears the profile state to idle and loads the register defaults
// (ramp_steps 100, hold_periods 100, top_speed 5000); no output beat is pending.
module oscillating_trapezoid_velocity_profile_unit
  import ovtp_pkg::*;
#(
  parameter int PAUSE_TICKS = PAUSE_TICKS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [CFG_IDX_W-1:0]    wr_index,
  input  logic [CFG_DATA_W-1:0]   wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic                    button_pressed,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEL_W-1:0] velocity,
  output logic                    finished
);

  logic [STEPS_W-1:0] ramp_steps;
  logic [HOLD_W-1:0]  hold_periods;
  logic [SPEED_W-1:0] top_speed;
  ovtp_cmd_t          cmd;
  ovtp_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_steps   <= RAMP_STEPS_RST;
      hold_periods <= HOLD_PERIODS_RST;
      top_speed    <= TOP_SPEED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RAMP_STEPS:   ramp_steps   <= wr_data[STEPS_W-1:0];
        REG_HOLD_PERIODS: hold_periods <= wr_data[HOLD_W-1:0];
        REG_TOP_SPEED:    top_speed    <= wr_data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ovtp_ctrl #(
    .PAUSE_TICKS(PAUSE_TICKS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .button_pressed(button_pressed),
    .ramp_steps(ramp_steps),
    .hold_periods(hold_periods),
    .cmd(cmd),
    .status(status)
  );

  ovtp_dp u_dp (
    .clk(clk),
    .rst(rst),
    .ramp_steps(ramp_steps),
    .top_speed(top_speed),
    .cmd(cmd),
    .status(status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .velocity(velocity),
    .finished(finished)
  );

  a_abort_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> velocity == '0)
    else $error("abort beat with nonzero velocity");

  a_load_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input not stalled while dividing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !(out_valid && out_stall))
    else $error("held output beat overwritten");

endmodule

/* verif/testbench.sv */
module testbench;
  import ovtp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCEL_FWD,
    ST_CRUISE_FWD,
    ST_DECEL_FWD,
    ST_DWELL,
    ST_ACCEL_REV,
    ST_CRUISE_REV,
    ST_DECEL_REV
  } profile_state_e;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef struct packed {
    logic act;
    logic btn;
  } tick_item_t;

  typedef struct packed {
    logic [VEL_W-1:0] vel;
    logic             fin;
  } motion_cmd_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    wr_index = REG_RAMP_STEPS;
  logic [CFG_DATA_W-1:0]   wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    action = ACT_TICK;
  logic                    button_pressed = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VEL_W-1:0] velocity;
  logic                    finished;

  oscillating_trapezoid_velocity_profile_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .button_pressed (button_pressed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .velocity       (velocity),
    .finished       (finished)
  );

  // profile model state and register shadow
  logic [STEPS_W-1:0] cfg_ramp  = RAMP_STEPS_RST;
  logic [HOLD_W-1:0]  cfg_hold  = HOLD_PERIODS_RST;
  logic [SPEED_W-1:0] cfg_speed = TOP_SPEED_RST;
  profile_state_e     prof_st   = ST_IDLE;
  logic [STEPS_W-1:0] prof_idx  = '0;
  logic [HOLD_W-1:0]  prof_hold = '0;
  logic [TICK_W-1:0]  prof_wait = '0;

  tick_item_t  tick_q[$];
  motion_cmd_t expected_cmds[$];

  int mismatches = 0;
  int beats_in = 0;
  int cmds_seen = 0;
  int aborts_seen = 0;
  int settings_used = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [VEL_W-1:0] signed_vel(input int unsigned mag, input logic rev);
    return rev ? VEL_W'(0 - mag) : VEL_W'(mag);
  endfunction

  function automatic void abort_run(output logic got, output motion_cmd_t cmd);
    prof_st   = ST_IDLE;
    prof_idx  = '0;
    prof_hold = '0;
    prof_wait = '0;
    got       = 1'b1;
    cmd.vel   = '0;
    cmd.fin   = 1'b1;
  endfunction

  function automatic void at_boundary(input logic btn, output logic got,
                                      output motion_cmd_t cmd);
    int unsigned steps;
    int unsigned holds;
    int unsigned i;
    logic rev;
    logic drop;
    steps = (cfg_ramp == 0) ? 1 : cfg_ramp;
    holds = (cfg_hold == 0) ? 1 : cfg_hold;
    got   = 1'b0;
    cmd   = '0;
    drop  = 1'b0;
    if (prof_st == ST_IDLE) return;
    // button is not looked at where the dwell begins
    if (btn && prof_st != ST_DWELL) begin
      abort_run(got, cmd);
      return;
    end
    rev = (prof_st >= ST_ACCEL_REV);
    case (prof_st)
      ST_ACCEL_FWD, ST_ACCEL_REV: begin
        i = (prof_idx < steps) ? prof_idx : steps;
        got = 1'b1;
        cmd.vel = signed_vel((cfg_speed * i) / steps, rev);
        prof_wait = RAMP_TICKS;
        if (i >= steps) begin
          prof_st = rev ? ST_CRUISE_REV : ST_CRUISE_FWD;
          prof_hold = '0;
        end else begin
          prof_idx = STEPS_W'(i + 1);
        end
      end
      ST_CRUISE_FWD, ST_CRUISE_REV: begin
        if (prof_hold == 0) begin
          got = 1'b1;
          cmd.vel = signed_vel(cfg_speed, rev);
        end
        if (prof_hold < holds) begin
          prof_hold = prof_hold + 1'b1;
          prof_wait = HOLD_TICKS;
        end else begin
          // hold end and first ramp-down step share a boundary
          prof_st = rev ? ST_DECEL_REV : ST_DECEL_FWD;
          prof_idx = STEPS_W'(steps);
          drop = 1'b1;
        end
      end
      ST_DWELL: begin
        prof_wait = TICK_W'(PAUSE_TICKS_DEF);
        prof_st = ST_ACCEL_REV;
        prof_idx = '0;
      end
      ST_DECEL_FWD, ST_DECEL_REV: drop = 1'b1;
      default: ;
    endcase
    if (drop) begin
      i = (prof_idx < steps) ? prof_idx : steps;
      if (i == 0) i = 1;
      got = 1'b1;
      cmd.vel = signed_vel((cfg_speed * i) / steps, rev);
      cmd.fin = 1'b0;
      prof_wait = RAMP_TICKS;
      if (i <= 1) begin
        prof_st = rev ? ST_ACCEL_FWD : ST_DWELL;
        prof_idx = '0;
      end else begin
        prof_idx = STEPS_W'(i - 1);
      end
    end
  endfunction

  function automatic void profile_step(input tick_item_t it, output logic got,
                                       output motion_cmd_t cmd);
    got = 1'b0;
    cmd = '0;
    if (prof_st == ST_IDLE) begin
      if (it.act != ACT_START) return;
      prof_st   = ST_ACCEL_FWD;
      prof_idx  = '0;
      prof_hold = '0;
      prof_wait = '0;
      at_boundary(it.btn, got, cmd);
      return;
    end
    if (it.act == ACT_START) return;
    if (prof_wait > 1) begin
      prof_wait = prof_wait - 1'b1;
      return;
    end
    prof_wait = '0;
    at_boundary(it.btn, got, cmd);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void push_item(input logic act, input logic btn);
    tick_item_t it;
    it.act = act;
    it.btn = btn;
    tick_q.push_back(it);
  endfunction

  // input driver
  int          in_gap = 0;
  logic        in_calm = 1'b0;
  tick_item_t  drv_item;
  logic        drv_got;
  motion_cmd_t drv_cmd;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        drv_item.act = action;
        drv_item.btn = button_pressed;
        profile_step(drv_item, drv_got, drv_cmd);
        if (drv_got) expected_cmds.push_back(drv_cmd);
        beats_in++;
      end
      if ($urandom_range(0, 299) == 0) in_calm = !in_calm;
      if (in_valid && in_stall) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        drv_item = tick_q.pop_front();
        in_valid <= 1'b1;
        action <= drv_item.act;
        button_pressed <= drv_item.btn;
        in_gap = in_calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor
  int          stall_left = 0;
  logic        out_calm = 1'b0;
  motion_cmd_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        cmds_seen++;
        if (finished) aborts_seen++;
        if (expected_cmds.size() == 0) begin
          note_mismatch($sformatf("unexpected beat: vel %0d fin %0b", velocity, finished));
        end else begin
          want = expected_cmds.pop_front();
          if (want.vel !== velocity || want.fin !== finished)
            note_mismatch($sformatf("mismatch: exp vel %0d fin %0b, got vel %0d fin %0b",
                                    $signed(want.vel), want.fin, velocity, finished));
        end
      end
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = out_calm ? 0 : pick_gap();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  task automatic settle();
    @(negedge clk);
    while (tick_q.size() != 0 || in_valid || expected_cmds.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_settings(input int ramp, input int hold, input int speed);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_RAMP_STEPS;
    wr_data <= CFG_DATA_W'(ramp);
    cfg_ramp = STEPS_W'(ramp);
    @(posedge clk);
    wr_index <= REG_HOLD_PERIODS;
    wr_data <= CFG_DATA_W'(hold);
    cfg_hold = HOLD_W'(hold);
    @(posedge clk);
    wr_index <= REG_TOP_SPEED;
    wr_data <= CFG_DATA_W'(speed);
    cfg_speed = SPEED_W'(speed);
    @(posedge clk);
    wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int phase_no;
    int rand_beats;
    int n;
    int r;
    int ramp;
    int hold;
    int speed;
    phase_no = 0;
    rand_beats = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: degenerate registers, run one forward half, press at the dwell start
    apply_settings(0, 0, 16383);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_START, 1'b1);
    push_item(ACT_START, 1'b0);
    push_item(ACT_START, 1'b0);
    for (n = 1; n <= 16; n++) push_item(ACT_TICK, (n == 15 || n == 16));
    push_item(ACT_TICK, 1'b1);
    settle();

    while ((rand_beats < 1150 || cmds_seen < 60) && phase_no < 40) begin
      case (phase_no % 6)
        0: begin
          ramp = $urandom_range(1, 6);
          hold = $urandom_range(0, 3);
          speed = $urandom_range(0, 16383);
        end
        1: begin
          ramp = 1;
          hold = 1;
          speed = 16383;
        end
        2: begin
          ramp = $urandom_range(0, 12);
          hold = $urandom_range(0, 12);
          speed = $urandom_range(100, 10000);
        end
        3: begin
          ramp = 255;
          hold = 255;
          speed = $urandom_range(0, 16383);
        end
        4: begin
          ramp = $urandom_range(2, 5);
          hold = 0;
          speed = 0;
        end
        default: begin
          ramp = 200;
          hold = $urandom_range(10, 200);
          speed = $urandom_range(9000, 16383);
        end
      endcase
      apply_settings(ramp, hold, speed);
      for (n = 0; n < 100; n++) begin
        r = $urandom_range(0, 999);
        if (r < 40) push_item(ACT_START, (r < 8));
        else push_item(ACT_TICK, (r >= 995));
      end
      rand_beats += 100;
      phase_no++;
      settle();
    end

    repeat (40) @(posedge clk);
    foreach (expected_cmds[k])
      note_mismatch($sformatf("missing beat: vel %0d fin %0b",
                              $signed(expected_cmds[k].vel), expected_cmds[k].fin));
    $display("tb: %0d input beats over %0d register settings", beats_in, settings_used);
    $display("tb: %0d velocity commands checked, %0d aborts, %0d mismatches",
             cmds_seen, aborts_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
